// ===== sv/mfs_pkg.sv =====
// shared types, constants and codes of the metaball field shader
package mfs_pkg;

  // default number of ball entries
  localparam int unsigned BALL_COUNT_DEFAULT = 5;

  // field widths
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned RAD_W    = 8;
  localparam int unsigned HUE_W    = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned SAT_W    = 8;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned DOM_W    = 3;

  // arithmetic widths: numerator is r*r*256, squared distance below 2^23
  localparam int unsigned NUM_W = 2 * RAD_W + 8;
  localparam int unsigned DSQ_W = 23;

  // shading constants
  localparam int unsigned FIELD_THRESHOLD = 256;
  localparam int unsigned INSIDE_BASE     = 120;
  localparam int unsigned GLOW_MAX        = 40;
  localparam int unsigned VAL_MAX         = 255;
  localparam int unsigned INSIDE_SAT_RST  = 200;
  localparam int unsigned OUTSIDE_SAT_RST = 180;

  // configuration register indexes
  typedef enum logic {
    CFG_INSIDE_SAT  = 1'b0,
    CFG_OUTSIDE_SAT = 1'b1
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_SHADE
  } state_e;

  // one ball table entry
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RAD_W-1:0]          radius;
    logic [HUE_W-1:0]          hue;
  } ball_t;

  // one finished contribution, in ball order
  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] value;
    logic [HUE_W-1:0] hue;
  } contrib_t;

endpackage

// ===== sv/mfs_ball_mem.sv =====
// ball table memory: one write port, one registered read port
module mfs_ball_mem import mfs_pkg::*; #(
  parameter int unsigned BallCount = BALL_COUNT_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  logic [((BallCount > 1) ? $clog2(BallCount) : 1)-1:0] wr_addr_i,
  input  ball_t wr_data_i,
  input  logic rd_en_i,
  input  logic [((BallCount > 1) ? $clog2(BallCount) : 1)-1:0] rd_addr_i,
  output logic rd_valid_o,
  output ball_t rd_data_o
);

  ball_t mem_q [BallCount];
  ball_t rd_data_q;
  logic  rd_valid_q;

  // storage and read data register
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // read data valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_en_i;
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_data_o  = rd_data_q;

endmodule

// ===== sv/mfs_contrib_pipe.sv =====
// contribution pipeline: distance, squares, then one quotient bit per stage
module mfs_contrib_pipe import mfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ball_t               ball_i,
  input  logic [SAMPLE_W-1:0] sample_x_i,
  input  logic [SAMPLE_W-1:0] sample_y_i,
  output contrib_t            contrib_o
);

  localparam int unsigned DiffW = COORD_W + 1;
  localparam int unsigned AbsW  = COORD_W;
  localparam int unsigned SqW   = 2 * AbsW;
  localparam int unsigned RrW   = 2 * RAD_W;

  // stage 1: absolute distances
  logic signed [DiffW-1:0] dx, dy;
  logic [AbsW-1:0]         adx, ady;
  logic                    v1_q;
  logic [AbsW-1:0]         adx_q, ady_q;
  logic [RAD_W-1:0]        rad1_q;
  logic [HUE_W-1:0]        hue1_q;

  always_comb begin
    dx  = $signed({2'b00, sample_x_i}) - $signed({ball_i.x[COORD_W-1], ball_i.x});
    dy  = $signed({2'b00, sample_y_i}) - $signed({ball_i.y[COORD_W-1], ball_i.y});
    adx = dx[DiffW-1] ? AbsW'(-dx) : AbsW'(dx);
    ady = dy[DiffW-1] ? AbsW'(-dy) : AbsW'(dy);
  end

  always_ff @(posedge clk_i) begin
    adx_q  <= adx;
    ady_q  <= ady;
    rad1_q <= ball_i.radius;
    hue1_q <= ball_i.hue;
  end

  // stage 2: squares
  logic           v2_q;
  logic [SqW-1:0] sqx_q, sqy_q;
  logic [RrW-1:0] rr_q;
  logic [HUE_W-1:0] hue2_q;

  always_ff @(posedge clk_i) begin
    sqx_q  <= SqW'(adx_q) * SqW'(adx_q);
    sqy_q  <= SqW'(ady_q) * SqW'(ady_q);
    rr_q   <= RrW'(rad1_q) * RrW'(rad1_q);
    hue2_q <= hue1_q;
  end

  // stage 3 feeds the divider: squared distance clamped to a minimum of one
  logic [DSQ_W-1:0] dsq_sum, dsq;

  always_comb begin
    dsq_sum = DSQ_W'(sqx_q) + DSQ_W'(sqy_q);
    dsq     = (dsq_sum == '0) ? DSQ_W'(1) : dsq_sum;
  end

  // divider stages, index 0 is the input register
  logic             dv_q  [NUM_W+1];
  logic [DSQ_W-1:0] rem_q [NUM_W+1];
  logic [NUM_W-1:0] num_q [NUM_W+1];
  logic [NUM_W-1:0] quo_q [NUM_W+1];
  logic [DSQ_W-1:0] div_q [NUM_W+1];
  logic [HUE_W-1:0] dh_q  [NUM_W+1];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    num_q[0] <= {rr_q, 8'h00};
    quo_q[0] <= '0;
    div_q[0] <= dsq;
    dh_q[0]  <= hue2_q;
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      dv_q[0]  <= 1'b0;
    end else begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      dv_q[0]  <= v2_q;
    end
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_div
    logic [DSQ_W:0] trial, diff;
    logic           ge;

    // restoring step: shift in the next numerator bit and try a subtract
    always_comb begin
      trial = {rem_q[s], num_q[s][NUM_W-1]};
      diff  = trial - {1'b0, div_q[s]};
      ge    = (trial >= {1'b0, div_q[s]});
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? diff[DSQ_W-1:0] : trial[DSQ_W-1:0];
      num_q[s+1] <= {num_q[s][NUM_W-2:0], 1'b0};
      quo_q[s+1] <= {quo_q[s][NUM_W-2:0], ge};
      div_q[s+1] <= div_q[s];
      dh_q[s+1]  <= dh_q[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else begin
        dv_q[s+1] <= dv_q[s];
      end
    end
  end

  assign contrib_o.valid = dv_q[NUM_W];
  assign contrib_o.value = quo_q[NUM_W];
  assign contrib_o.hue   = dh_q[NUM_W];

endmodule

// ===== sv/metaball_field_shader.sv =====
// top level: ball table, contribution pipeline, field accumulation and shading
//
// channel | handshake           | word
// --------+---------------------+---------------------------------------------
// command | start / busy        | action, ball slot/x/y/radius/hue, sample x/y
// result  | done_o strobe       | hue, saturation, brightness, inside, dominant
// config  | cfg_we_i, cfg_idx_i | cfg_data_i (saturation registers)
//
// a load word writes its table entry and leaves busy low
// an evaluate word makes one table read per ball and passes each ball through
// three distance stages and a 24-stage restoring divider
// reset clears the sequencer and sets the saturation registers; table entries
// hold garbage until loaded
// the receiver cannot stall: done_o is high for one cycle per evaluate word
module metaball_field_shader import mfs_pkg::*; #(
  parameter int unsigned BallCount = BALL_COUNT_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                action_i,
  input  logic [SLOT_W-1:0]   ball_slot_i,
  input  logic [COORD_W-1:0]  ball_x_i,
  input  logic [COORD_W-1:0]  ball_y_i,
  input  logic [RAD_W-1:0]    ball_radius_i,
  input  logic [HUE_W-1:0]    ball_hue_i,
  input  logic [SAMPLE_W-1:0] sample_x_i,
  input  logic [SAMPLE_W-1:0] sample_y_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [SAT_W-1:0]    cfg_data_i,
  output logic                done_o,
  output logic [HUE_W-1:0]    hue_o,
  output logic [SAT_W-1:0]    saturation_o,
  output logic [VAL_W-1:0]    brightness_o,
  output logic                inside_surface_o,
  output logic [DOM_W-1:0]    dominant_ball_o
);

  localparam int unsigned IdxW   = (BallCount > 1) ? $clog2(BallCount) : 1;
  localparam int unsigned CntW   = $clog2(BallCount + 1);
  localparam int unsigned FieldW = NUM_W + $clog2(BallCount);
  localparam int unsigned GlowW  = 15;

  state_e state_q, state_d;
  logic [CntW-1:0] issue_cnt_q, recv_cnt_q;
  logic [SAMPLE_W-1:0] sample_x_q, sample_y_q;
  logic [FieldW-1:0] field_q;
  logic [NUM_W-1:0] best_q;
  logic [HUE_W-1:0] best_hue_q;
  logic [IdxW-1:0] dom_q;
  logic [SAT_W-1:0] isat_q, osat_q;
  logic done_q;
  logic [HUE_W-1:0] hue_q;
  logic [SAT_W-1:0] sat_q;
  logic [VAL_W-1:0] bright_q;
  logic inside_q;
  logic [DOM_W-1:0] dom_out_q;

  logic accept, eval_go, load_we, rd_en, shade_en;
  ball_t wr_data, rd_data;
  logic rd_valid;
  contrib_t contrib;

  // command acceptance
  assign accept  = start & ~busy;
  assign eval_go = accept & action_i;
  assign load_we = accept & ~action_i & (int'(ball_slot_i) < BallCount);

  assign wr_data.x      = $signed(ball_x_i);
  assign wr_data.y      = $signed(ball_y_i);
  assign wr_data.radius = ball_radius_i;
  assign wr_data.hue    = ball_hue_i;

  // ball table; a load lands before any read of the next evaluate
  mfs_ball_mem #(
    .BallCount(BallCount)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load_we),
    .wr_addr_i (IdxW'(ball_slot_i)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_cnt_q[IdxW-1:0]),
    .rd_valid_o(rd_valid),
    .rd_data_o (rd_data)
  );

  // per-ball contribution
  mfs_contrib_pipe u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(rd_valid),
    .ball_i    (rd_data),
    .sample_x_i(sample_x_q),
    .sample_y_i(sample_y_q),
    .contrib_o (contrib)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (eval_go) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (issue_cnt_q == CntW'(BallCount - 1)) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (recv_cnt_q == CntW'(BallCount)) state_d = ST_SHADE;
      end
      ST_SHADE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy     = 1'b1;
    rd_en    = 1'b0;
    shade_en = 1'b0;
    case (state_q)
      ST_IDLE:  busy     = 1'b0;
      ST_ISSUE: rd_en    = 1'b1;
      ST_WAIT:  busy     = 1'b1;
      ST_SHADE: shade_en = 1'b1;
      default:  busy     = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_cnt_q <= '0;
      recv_cnt_q  <= '0;
      done_q      <= 1'b0;
      isat_q      <= SAT_W'(INSIDE_SAT_RST);
      osat_q      <= SAT_W'(OUTSIDE_SAT_RST);
    end else begin
      state_q <= state_d;
      done_q  <= shade_en;
      if (eval_go) begin
        issue_cnt_q <= '0;
      end else if (rd_en) begin
        issue_cnt_q <= issue_cnt_q + CntW'(1);
      end
      if (eval_go) begin
        recv_cnt_q <= '0;
      end else if (contrib.valid) begin
        recv_cnt_q <= recv_cnt_q + CntW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INSIDE_SAT:  isat_q <= cfg_data_i;
          CFG_OUTSIDE_SAT: osat_q <= cfg_data_i;
          default:         isat_q <= isat_q;
        endcase
      end
    end
  end

  // field sum and dominant ball; ball 0 always seeds the maximum
  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      sample_x_q <= sample_x_i;
      sample_y_q <= sample_y_i;
      field_q    <= '0;
    end else if (contrib.valid) begin
      field_q <= field_q + FieldW'(contrib.value);
      if ((recv_cnt_q == '0) || (contrib.value > best_q)) begin
        best_q     <= contrib.value;
        best_hue_q <= contrib.hue;
        dom_q      <= recv_cnt_q[IdxW-1:0];
      end
    end
  end

  // shading
  logic             in_surface;
  logic [FieldW-1:0] excess4;
  logic [VAL_W-1:0] bright_in, bright_out;
  logic [GlowW-1:0] glow_prod;
  logic [6:0]       glow;

  always_comb begin
    in_surface = field_q > FieldW'(FIELD_THRESHOLD);
    excess4   = (field_q - FieldW'(FIELD_THRESHOLD)) >> 2;
    bright_in = (excess4 > FieldW'(VAL_MAX - INSIDE_BASE)) ? VAL_W'(VAL_MAX)
              : VAL_W'(INSIDE_BASE) + excess4[VAL_W-1:0];
    glow_prod = GlowW'(field_q[8:0]) * GlowW'(GLOW_MAX);
    glow      = glow_prod[GlowW-1:8];
    bright_out = (glow > 7'(GLOW_MAX)) ? VAL_W'(GLOW_MAX) : {1'b0, glow};
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (shade_en) begin
      hue_q     <= best_hue_q;
      sat_q     <= in_surface ? isat_q : osat_q;
      bright_q  <= in_surface ? bright_in : bright_out;
      inside_q  <= in_surface;
      dom_out_q <= DOM_W'(dom_q);
    end
  end

  assign done_o           = done_q;
  assign hue_o            = hue_q;
  assign saturation_o     = sat_q;
  assign brightness_o     = bright_q;
  assign inside_surface_o = inside_q;
  assign dominant_ball_o  = dom_out_q;

`ifndef NO_ASSERTIONS
  // a result word only follows the shading cycle
  a_done_after_shade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_SHADE))
    else $error("result strobe without shading cycle");

  // contributions arrive only while the sequencer waits for them
  a_contrib_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    contrib.valid |-> (state_q == ST_WAIT))
    else $error("contribution outside wait state");

  // no more contributions than balls
  a_recv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recv_cnt_q <= CntW'(BallCount))
    else $error("contribution count overflow");

  // an accepted evaluate makes the block busy
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i) |=> busy)
    else $error("evaluate accepted without going busy");

  // a load never causes a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !action_i) |=> !done_o)
    else $error("load produced a result");
`endif

endmodule
